// ===== design/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants and operation codes for the flag bitmap with
// find-next-set search.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int FUNC_W        = 3;
    localparam int IDX_W         = 10;
    localparam int FLAG_CNT_W    = 11;
    localparam int MAX_FLAGS_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;

    // Count after reset; the store is filled below this at reset.
    localparam logic [FLAG_CNT_W-1:0] FLAG_COUNT_RST = 11'd1024;

    // Operation codes carried by the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_FILL  = 3'd0,
        FUNC_SET   = 3'd1,
        FUNC_CLEAR = 3'd2,
        FUNC_READ  = 3'd3,
        FUNC_FIND  = 3'd4
    } t_func;

endpackage

// ===== design/bitmap_flag_set_find_next_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_flag_set_find_next_unit
// Sequence: set/clear/read go through address, word and done states; rejects
//   and unused codes go straight to done; find walks up to NUM_WORDS words; fill
//   writes all NUM_WORDS words. Throughput: one item at a time; the single read
//   port of the word store walks one word per cycle.
// Reset: synchronous, active low. After reset a fill pass writes all
//   NUM_WORDS words (ones below 1024, zeros above) before the first item.
// ----------------------------------------------------------------------------
// Flag bitmap held in a word-wide synchronous memory. Every item is handled
// by a small sequencer that reads a word and, for set and clear, writes it
// back modified, walks words upward looking for the lowest set flag in range,
// or rewrites every word for a fill. The result waits in an output register
// so the next item can be taken while the previous result is still stalled downstream.
// ----------------------------------------------------------------------------
module bitmap_flag_set_find_next_unit #(
    parameter int MAX_FLAGS = bfs_pkg::MAX_FLAGS_DEF,
    parameter int WORD_BITS = bfs_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [bfs_pkg::FLAG_CNT_W-1:0] i_cfg_wr_data,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bfs_pkg::FUNC_W-1:0]    i_func,
    input  logic [bfs_pkg::IDX_W-1:0]     i_flag_index,
    input  logic                          i_include_start,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_flag_value,
    output logic                          o_found,
    output logic [bfs_pkg::IDX_W-1:0]     o_found_index,
    output logic                          o_out_of_range
);

    import bfs_pkg::*;

    localparam int NUM_WORDS = (MAX_FLAGS + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_BITS  = NUM_WORDS * WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(NUM_BITS + WORD_BITS + 1);
    localparam int CMP_W     = (BASE_W > FLAG_CNT_W + 1) ? BASE_W : FLAG_CNT_W + 1;
    // word address by reciprocal multiply: positions stay below 2^RECIP_SH
    localparam int RECIP_SH  = FLAG_CNT_W;
    localparam int RECIP     = (1 << RECIP_SH) / WORD_BITS;
    localparam int PROD_W    = RECIP_SH + $clog2(RECIP + 1);
    // limit used by the fill pass after reset
    localparam int INIT_LIM  = (MAX_FLAGS < 1024) ? MAX_FLAGS : 1024;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_WORD,
        S_FILL,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [FLAG_CNT_W-1:0] r_flag_count;
    logic [FUNC_W-1:0]     r_func;
    logic [CMP_W-1:0]      r_pos;
    logic [PROD_W-1:0]     r_prod;
    logic [CMP_W-1:0]      r_limit;
    logic [ADDR_W-1:0]     r_word;
    logic [CMP_W-1:0]      r_base;
    logic [BIT_W-1:0]      r_bit;

    logic                  r_res_value;
    logic                  r_res_found;
    logic [IDX_W-1:0]      r_res_index;
    logic                  r_res_oor;

    logic                  r_out_valid;
    logic                  r_out_value;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_index;
    logic                  r_out_oor;

    // accept-side values
    logic                  in_take;
    logic [CMP_W-1:0]      cur_limit;
    logic [CMP_W-1:0]      n_pos;
    logic                  n_oor;

    // address split of r_pos into word and bit
    logic [CMP_W-1:0]      q_est;
    logic [CMP_W-1:0]      rem_est;
    logic [CMP_W-1:0]      n_quot;
    logic [CMP_W-1:0]      n_rem;

    // word walk
    logic [CMP_W-1:0]      n_base;
    logic                  walk_end;
    logic                  last_word;

    // memory and scan hookups
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0]  mem_rdata;
    logic [CMP_W-1:0]      scan_start;
    logic [WORD_BITS-1:0]  scan_mask;
    logic                  scan_hit;
    logic [BIT_W-1:0]      scan_bit;
    logic [WORD_BITS-1:0]  bit_sel;
    logic                  slot_free;

    bfs_mem #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // fill passes window from the word base; searches from the start position
    assign scan_start = (r_state == S_WORD) ? r_pos : r_base;

    bfs_scan #(
        .WORD_BITS (WORD_BITS),
        .CMP_W     (CMP_W),
        .BIT_W     (BIT_W)
    ) u_scan (
        .i_word  (mem_rdata),
        .i_base  (r_base),
        .i_start (scan_start),
        .i_limit (r_limit),
        .o_mask  (scan_mask),
        .o_hit   (scan_hit),
        .o_bit   (scan_bit)
    );

    always_comb begin
        in_take   = i_in_valid && (r_state == S_IDLE);
        // clamp the count to the store size
        cur_limit = (CMP_W'(r_flag_count) > CMP_W'(MAX_FLAGS)) ?
                    CMP_W'(MAX_FLAGS) : CMP_W'(r_flag_count);
        // exclusive search starts one past the index
        n_pos = (i_func == FUNC_FIND && !i_include_start) ?
                CMP_W'(i_flag_index) + CMP_W'(1) : CMP_W'(i_flag_index);
        n_oor = (i_func == FUNC_SET || i_func == FUNC_CLEAR ||
                 i_func == FUNC_READ || i_func == FUNC_FIND) &&
                (CMP_W'(i_flag_index) >= cur_limit);

        // estimate is low by at most one word; correct once
        q_est   = CMP_W'(r_prod >> RECIP_SH);
        rem_est = r_pos - CMP_W'(q_est * CMP_W'(WORD_BITS));
        if (rem_est >= CMP_W'(WORD_BITS)) begin
            n_quot = q_est + CMP_W'(1);
            n_rem  = rem_est - CMP_W'(WORD_BITS);
        end else begin
            n_quot = q_est;
            n_rem  = rem_est;
        end

        n_base    = r_base + CMP_W'(WORD_BITS);
        walk_end  = (n_base >= r_limit);
        last_word = (r_word == ADDR_W'(NUM_WORDS - 1));
        bit_sel   = WORD_BITS'(1) << r_bit;
        slot_free = !r_out_valid || !i_out_stall;

        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = scan_mask;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(n_quot);

        unique case (r_state)
            S_INIT, S_FILL: begin
                mem_we = 1'b1;
            end
            S_ADDR: begin
                mem_re = 1'b1;
            end
            S_WORD: begin
                if (r_func == FUNC_SET) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | bit_sel;
                end else if (r_func == FUNC_CLEAR) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~bit_sel;
                end else if (r_func == FUNC_FIND && !scan_hit && !walk_end) begin
                    // prefetch the next word while this one is checked
                    mem_re    = 1'b1;
                    mem_raddr = r_word + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_flag_count <= FLAG_COUNT_RST;
            r_word       <= '0;
            r_base       <= '0;
            r_limit      <= CMP_W'(INIT_LIM);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_flag_count <= i_cfg_wr_data;
            end

            // drop the result once taken, unless a new one loads below
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT, S_FILL: begin
                    // one word per cycle, ones below the limit
                    r_word <= r_word + ADDR_W'(1);
                    r_base <= n_base;
                    if (last_word) begin
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_func      <= i_func;
                        r_pos       <= n_pos;
                        r_prod      <= PROD_W'(n_pos) * PROD_W'(RECIP);
                        r_limit     <= cur_limit;
                        r_word      <= '0;
                        r_base      <= '0;
                        r_res_value <= 1'b0;
                        r_res_found <= 1'b0;
                        r_res_index <= '0;
                        r_res_oor   <= n_oor;
                        if (i_func == FUNC_FILL) begin
                            r_state <= S_FILL;
                        end else if (n_oor || i_func > FUNC_FIND) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    r_word <= ADDR_W'(n_quot);
                    r_base <= r_pos - n_rem;
                    r_bit  <= BIT_W'(n_rem);
                    // exclusive start at the last flag finds nothing
                    if (r_func == FUNC_FIND && r_pos >= r_limit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WORD;
                    end
                end
                S_WORD: begin
                    if (r_func == FUNC_FIND) begin
                        if (scan_hit) begin
                            r_res_found <= 1'b1;
                            r_res_index <= IDX_W'(r_base + CMP_W'(scan_bit));
                            r_state     <= S_DONE;
                        end else if (walk_end) begin
                            r_state <= S_DONE;
                        end else begin
                            // advance to the next word
                            r_word <= r_word + ADDR_W'(1);
                            r_base <= n_base;
                        end
                    end else begin
                        if (r_func == FUNC_READ) begin
                            r_res_value <= mem_rdata[r_bit];
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_found <= r_res_found;
                        r_out_index <= r_res_index;
                        r_out_oor   <= r_res_oor;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_flag_value   = r_out_value;
    assign o_found        = r_out_found;
    assign o_found_index  = r_out_index;
    assign o_out_of_range = r_out_oor;

endmodule

// ===== design/bfs_mem.sv =====
// ----------------------------------------------------------------------------
// bfs_mem
// Word store of the flag bitmap: one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module bfs_mem #(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 16,
    parameter int ADDR_W    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bfs_scan.sv =====
// ----------------------------------------------------------------------------
// bfs_scan
// Window mask and lowest-set-bit search over one word of the bitmap.
// The window covers global indexes in [start, limit) within this word.
// ----------------------------------------------------------------------------
module bfs_scan #(
    parameter int WORD_BITS = 64,
    parameter int CMP_W     = 12,
    parameter int BIT_W     = 6
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CMP_W-1:0]     i_base,
    input  logic [CMP_W-1:0]     i_start,
    input  logic [CMP_W-1:0]     i_limit,
    output logic [WORD_BITS-1:0] o_mask,
    output logic                 o_hit,
    output logic [BIT_W-1:0]     o_bit
);

    logic [CMP_W-1:0] rel_lo;
    logic [CMP_W-1:0] rel_hi;

    always_comb begin
        rel_lo = (i_start > i_base) ? (i_start - i_base) : '0;
        rel_hi = (i_limit > i_base) ? (i_limit - i_base) : '0;
        o_hit  = 1'b0;
        o_bit  = '0;
        // walk down so the lowest set bit wins
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            o_mask[b] = (CMP_W'(b) >= rel_lo) && (CMP_W'(b) < rel_hi);
            if (o_mask[b] && i_word[b]) begin
                o_hit = 1'b1;
                o_bit = BIT_W'(b);
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flag bitmap with find-next-set search. A
// bit-level mirror of the bitmap predicts every result. A short directed
// pass covers the corner cases. Random phases then cover many flag counts,
// with the sender working in bursts and the receiver stalling on its own
// pattern.
// ----------------------------------------------------------------------------
module testbench;

    import bfs_pkg::*;

    localparam int NUM_FLAGS    = MAX_FLAGS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    // Longest search walks every word plus setup; hold this long at the end.
    localparam int DRAIN_CYCLES = 40;

    // Codes above the last operation do nothing and return all zeros.
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_FIRST = FUNC_W'(int'(FUNC_FIND) + 1);
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_LAST  = '1;

    typedef struct packed {
        logic             flag_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             out_of_range;
    } t_flag_result;

    // DUT inputs, all known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [FLAG_CNT_W-1:0] i_cfg_wr_data   = '0;
    logic                  i_in_valid      = 1'b0;
    logic [FUNC_W-1:0]     i_func          = FUNC_FILL;
    logic [IDX_W-1:0]      i_flag_index    = '0;
    logic                  i_include_start = 1'b0;
    logic                  i_out_stall     = 1'b0;

    // DUT outputs
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_flag_value;
    logic                  o_found;
    logic [IDX_W-1:0]      o_found_index;
    logic                  o_out_of_range;

    // Mirror of the bitmap and of the count register. Reset leaves every
    // flag below 1024 set.
    logic                  flag_mirror [NUM_FLAGS];
    logic [FLAG_CNT_W-1:0] flag_count_q = FLAG_COUNT_RST;

    t_flag_result          expected_results [$];

    int cycle_count     = 0;
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int search_hits     = 0;
    int range_errors    = 0;
    int count_writes    = 0;
    int burst_left      = 0;

    initial begin
        foreach (flag_mirror[k]) flag_mirror[k] = 1'b1;
    end

    bitmap_flag_set_find_next_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_flag_index    (i_flag_index),
        .i_include_start (i_include_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_flag_value    (o_flag_value),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_out_of_range  (o_out_of_range)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle counter doubles as the run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern: rotate through no stall, light random stall,
    // heavy random stall and a fixed periodic pattern so the stalls land on
    // every phase of a search.
    always @(negedge i_clk) begin
        case ((cycle_count / 256) % 4)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= ((cycle_count % 7) < 3);
            end
        endcase
    end

    // Predict one operation against the mirror and advance the mirror.
    function automatic t_flag_result predict_flag_op(input logic [FUNC_W-1:0] func,
                                                     input logic [IDX_W-1:0]  idx,
                                                     input logic              incl);
        t_flag_result res;
        int           bound;
        int           j;
        res   = '0;
        // A count beyond the store acts as the store size.
        bound = (flag_count_q > NUM_FLAGS) ? NUM_FLAGS : int'(flag_count_q);
        if (func == FUNC_FILL) begin
            // Fill rewrites the whole store, so flags above the count drop.
            for (j = 0; j < NUM_FLAGS; j++) flag_mirror[j] = (j < bound);
        end else if (func <= FUNC_FIND) begin
            if (int'(idx) >= bound) begin
                res.out_of_range = 1'b1;
            end else begin
                case (t_func'(func))
                    FUNC_SET: begin
                        flag_mirror[idx] = 1'b1;
                    end
                    FUNC_CLEAR: begin
                        flag_mirror[idx] = 1'b0;
                    end
                    FUNC_READ: begin
                        res.flag_value = flag_mirror[idx];
                    end
                    default: begin
                        // Search stops at the count; flags above it are never found.
                        for (j = incl ? int'(idx) : int'(idx) + 1; j < bound; j++) begin
                            if (flag_mirror[j]) begin
                                res.found       = 1'b1;
                                res.found_index = j[IDX_W-1:0];
                                break;
                            end
                        end
                    end
                endcase
            end
        end
        return res;
    endfunction

    // Drive one item, hold it until accepted, then record its expected result.
    // The sender works in bursts; between bursts it drops valid for a gap.
    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic [IDX_W-1:0]  idx,
                             input logic              incl);
        int gap;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_func          <= func;
        i_flag_index    <= idx;
        i_include_start <= incl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_flag_op(func, idx, incl));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Drop valid and wait until every result is back and the block takes input.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0 || o_in_stall) @(negedge i_clk);
    endtask

    // Write the count register while the block is idle.
    task automatic apply_flag_count(input logic [FLAG_CNT_W-1:0] count);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        flag_count_q  = count;
        count_writes++;
    endtask

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_flag_result exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no item pending: value=%0d found=%0d index=%0d oor=%0d",
                       o_flag_value, o_found, o_found_index, o_out_of_range);
                fail_count++;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (exp_res.found) search_hits++;
                if (exp_res.out_of_range) range_errors++;
                if (o_flag_value !== exp_res.flag_value) begin
                    $error("flag_value: expected %0d, actual %0d",
                           exp_res.flag_value, o_flag_value);
                    fail_count++;
                end
                if (o_found !== exp_res.found) begin
                    $error("found: expected %0d, actual %0d", exp_res.found, o_found);
                    fail_count++;
                end
                if (o_found_index !== exp_res.found_index) begin
                    $error("found_index: expected %0d, actual %0d",
                           exp_res.found_index, o_found_index);
                    fail_count++;
                end
                if (o_out_of_range !== exp_res.out_of_range) begin
                    $error("out_of_range: expected %0d, actual %0d",
                           exp_res.out_of_range, o_out_of_range);
                    fail_count++;
                end
            end
        end
    end

    // Full bitmap after reset: end flags, exclusive search from the last
    // flag, word-boundary clears and the unused operation codes.
    task automatic test_reset_image();
        send_item(FUNC_READ, '0, 1'b0);
        send_item(FUNC_READ, '1, 1'b1);
        send_item(FUNC_FIND, '1, 1'b0);
        send_item(FUNC_FIND, '1, 1'b1);
        send_item(FUNC_CLEAR, '0, 1'b0);
        send_item(FUNC_FIND, '0, 1'b1);
        send_item(FUNC_CLEAR, '1, 1'b0);
        send_item(FUNC_READ, '1, 1'b0);
        send_item(FUNC_SET, '1, 1'b1);
        send_item(FUNC_FIND, 10'd1022, 1'b0);
        send_item(FUNC_RESERVED_FIRST, '1, 1'b1);
        send_item(FUNC_RESERVED_FIRST + FUNC_W'(1), '0, 1'b0);
        send_item(FUNC_RESERVED_LAST, 10'd512, 1'b1);
    endtask

    // Count of zero: everything is out of range and fill empties the store.
    task automatic test_count_zero();
        apply_flag_count('0);
        send_item(FUNC_READ, '0, 1'b0);
        send_item(FUNC_FILL, '1, 1'b1);
        send_item(FUNC_FIND, '0, 1'b1);
    endtask

    // Count above the store size, with searches that walk every word.
    task automatic test_count_beyond_store();
        apply_flag_count('1);
        send_item(FUNC_FIND, '0, 1'b1);
        send_item(FUNC_SET, '1, 1'b0);
        send_item(FUNC_SET, 10'd64, 1'b1);
        send_item(FUNC_FIND, '0, 1'b1);
        send_item(FUNC_FIND, 10'd64, 1'b0);
    endtask

    // Lower the count to exactly one word: stale flags above it stay hidden
    // until a fill clears them.
    task automatic test_count_word_multiple();
        apply_flag_count(11'd64);
        send_item(FUNC_FIND, '0, 1'b1);
        send_item(FUNC_READ, '1, 1'b0);
        send_item(FUNC_FILL, '0, 1'b0);
        send_item(FUNC_FIND, 10'd63, 1'b0);
    endtask

    // One random phase at a given count. Starting from an empty store keeps
    // the bitmap sparse so searches walk far; fill_pct sets how often a fill
    // refills it.
    task automatic run_random_phase(input logic [FLAG_CNT_W-1:0] count,
                                    input bit                    start_empty,
                                    input int                    fill_pct,
                                    input int                    n_items);
        int                bound;
        int                roll;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
        if (start_empty) begin
            apply_flag_count('0);
            send_item(FUNC_FILL, IDX_W'($urandom), 1'($urandom));
        end
        apply_flag_count(count);
        bound = (count > NUM_FLAGS) ? NUM_FLAGS : int'(count);
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)                  func = FUNC_W'($urandom_range(FUNC_RESERVED_FIRST,
                                                                 FUNC_RESERVED_LAST));
            else if (roll < 3 + fill_pct)  func = FUNC_FILL;
            else if (roll < 40)            func = FUNC_SET;
            else if (roll < 52)            func = FUNC_CLEAR;
            else if (roll < 67)            func = FUNC_READ;
            else                           func = FUNC_FIND;
            // Mostly in range; a tenth anywhere so out-of-range items show up.
            if (bound == 0 || $urandom_range(0, 9) == 0)
                idx = IDX_W'($urandom_range(0, NUM_FLAGS - 1));
            else if ($urandom_range(0, 3) == 0)
                idx = IDX_W'($urandom_range(0, (bound - 1) / 8));
            else
                idx = IDX_W'($urandom_range(0, bound - 1));
            send_item(func, idx, 1'($urandom_range(0, 1)));
        end
    endtask

    // Walk a spread of counts: word multiples and their neighbors, the
    // extremes, a random one, and phases that keep the previous content.
    task automatic test_random_phases();
        run_random_phase(11'd1024, 1'b1, 0, 95);
        run_random_phase(11'd2047, 1'b1, 2, 95);
        run_random_phase(11'd1, 1'b1, 10, 95);
        run_random_phase(11'd64, 1'b1, 2, 95);
        run_random_phase(11'd65, 1'b0, 2, 95);
        run_random_phase(11'd1023, 1'b1, 0, 95);
        run_random_phase(11'd0, 1'b0, 5, 95);
        run_random_phase(11'd128, 1'b1, 2, 95);
        run_random_phase(11'd640, 1'b0, 1, 95);
        run_random_phase(FLAG_CNT_W'($urandom_range(1, 2047)), 1'b1, 2, 95);
        run_random_phase(11'd1024, 1'b0, 0, 95);
    endtask

    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_image();
        test_count_zero();
        test_count_beyond_store();
        test_count_word_multiple();
        test_random_phases();

        // Drain: everything back, then let a full search length pass.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items across %0d flag_count writes in %0d cycles.",
                 items_sent, count_writes, cycle_count);
        $display("Checked %0d results: %0d search hits, %0d out-of-range rejects.",
                 results_checked, search_hits, range_errors);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== bitmap_flag_set_find_next_unit.f =====
design/bfs_pkg.sv
design/bfs_mem.sv
design/bfs_scan.sv
design/bitmap_flag_set_find_next_unit.sv
test/testbench.sv
